### hw/rtl/rltm_pkg.sv
// ----------------------------------------------------------------------------
// rltm_pkg
// Shared types and constants of the request latency and throughput monitor.
// ----------------------------------------------------------------------------
package rltm_pkg;

    localparam int ID_W   = 32;
    localparam int TIME_W = 48;
    localparam int BMS_W  = 22;
    localparam int CNT_W  = 32;
    localparam int MEAN_W = 48;
    localparam int WIN_W  = 36;
    localparam int DIVR_W = 33;
    localparam int FRAC_W = 16;

    localparam logic [BMS_W-1:0] DEFAULT_BUCKET_MS = 22'd60000;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_FINISH = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DIV_MEAN = 2'd0,
        DIV_CUR  = 2'd1
    } div_sel_t;

    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   request_id;
        logic [TIME_W-1:0] now_ms;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [CNT_W-1:0]  completed_count;
        logic [MEAN_W-1:0] mean_latency;
        logic [CNT_W-1:0]  throughput_last_bucket;
        logic [WIN_W-1:0]  throughput_window;
    } rsp_t;

    typedef struct packed {
        logic     load;
        logic     search_step;
        logic     start_commit;
        logic     div_start;
        div_sel_t div_sel;
        logic     mean_commit;
        logic     cur_commit;
        logic     pos_commit;
        logic     sweep_step;
        logic     bump;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic search_fin;
        logic hit;
        logic div_busy;
        logic div_done;
        logic sweep_fin;
        logic out_free;
    } sts_t;

endpackage

### hw/rtl/rltm_stream_if.sv
// ----------------------------------------------------------------------------
// rltm_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rltm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/rltm_div.sv
// ----------------------------------------------------------------------------
// rltm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rltm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rltm_pkg::TIME_W-1:0] dividend,
    input  logic [rltm_pkg::DIVR_W-1:0] divisor,
    output logic [rltm_pkg::TIME_W-1:0] quotient,
    output logic                        busy,
    output logic                        done
);
    localparam int CW = $clog2(rltm_pkg::TIME_W);

    logic [rltm_pkg::TIME_W-1:0] q_reg;
    logic [rltm_pkg::DIVR_W-1:0] r_reg;
    logic [rltm_pkg::DIVR_W-1:0] d_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [rltm_pkg::DIVR_W:0]   trial;
    logic                        fits;

    assign trial = {r_reg, q_reg[rltm_pkg::TIME_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            q_reg    <= dividend;
            r_reg    <= '0;
            d_reg    <= divisor;
            cnt_reg  <= CW'(rltm_pkg::TIME_W - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[rltm_pkg::TIME_W-2:0], fits};
            r_reg <= fits ? rltm_pkg::DIVR_W'(trial - {1'b0, d_reg})
                          : trial[rltm_pkg::DIVR_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient  = q_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;
endmodule

### hw/rtl/rltm_ctrl.sv
// ----------------------------------------------------------------------------
// rltm_ctrl
// Sequencer: search, divisions, bucket sweep and result hand-off.
// ----------------------------------------------------------------------------
module rltm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  rltm_pkg::op_t        in_op,
    output logic                 in_ready,
    input  rltm_pkg::sts_t       sts,
    output rltm_pkg::cmd_t       cmd
);
    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SEARCH   = 9'b000000010,
        S_DIV_MEAN = 9'b000000100,
        S_CUR_GO   = 9'b000001000,
        S_DIV_CUR  = 9'b000010000,
        S_POS      = 9'b000100000,
        S_SWEEP    = 9'b001000000,
        S_BUMP     = 9'b010000000,
        S_EMIT     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_op)
                        rltm_pkg::OP_START:  state_next = S_SEARCH;
                        rltm_pkg::OP_FINISH: state_next = S_SEARCH;
                        rltm_pkg::OP_QUERY:  state_next = S_CUR_GO;
                        default:             state_next = S_EMIT;
                    endcase
                end
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (sts.search_fin)
                begin
                    if (sts.op == rltm_pkg::OP_FINISH)
                    begin
                        if (sts.hit)
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = rltm_pkg::DIV_MEAN;
                            state_next    = S_DIV_MEAN;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        cmd.start_commit = 1'b1;
                        state_next       = S_EMIT;
                    end
                end
            end
            S_DIV_MEAN:
            begin
                if (sts.div_done)
                begin
                    cmd.mean_commit = 1'b1;
                    state_next      = S_CUR_GO;
                end
            end
            S_CUR_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = rltm_pkg::DIV_CUR;
                state_next    = S_DIV_CUR;
            end
            S_DIV_CUR:
            begin
                if (sts.div_done)
                begin
                    cmd.cur_commit = 1'b1;
                    state_next     = S_POS;
                end
            end
            S_POS:
            begin
                cmd.pos_commit = 1'b1;
                state_next     = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_fin)
                begin
                    state_next = (sts.op == rltm_pkg::OP_FINISH) ? S_BUMP : S_EMIT;
                end
            end
            S_BUMP:
            begin
                cmd.bump   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result emitted while output register is occupied");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");
    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg != S_IDLE)
        else $error("transaction accepted without leaving idle");
`endif
endmodule

### hw/rtl/rltm_dp.sv
// ----------------------------------------------------------------------------
// rltm_dp
// Datapath: in-flight table, running mean, bucket ring and result register.
// ----------------------------------------------------------------------------
module rltm_dp #(
    parameter int IN_FLIGHT_ENTRIES = 16,
    parameter int WINDOW_BUCKETS    = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rltm_pkg::cmd_t             cmd,
    output rltm_pkg::sts_t             sts,
    input  rltm_pkg::req_t             req_data,
    input  logic                       cfg_valid,
    input  logic [rltm_pkg::BMS_W-1:0] cfg_data,
    output logic                       cfg_ready,
    input  logic                       rsp_ready,
    output logic                       rsp_valid,
    output rltm_pkg::rsp_t             rsp_data
);
    localparam int N    = IN_FLIGHT_ENTRIES;
    localparam int W    = WINDOW_BUCKETS;
    localparam int SW   = (N > 1) ? $clog2(N) : 1;
    localparam int SCW  = $clog2(N + 1);
    localparam int BW   = $clog2(W);
    localparam int BCW  = $clog2(W + 1);
    localparam int SUMW = rltm_pkg::CNT_W + BCW;
    localparam int TW   = rltm_pkg::TIME_W;
    localparam int CW   = rltm_pkg::CNT_W;

    rltm_pkg::req_t in_reg;
    logic [rltm_pkg::BMS_W-1:0] bms_reg;

    // in-flight table
    logic [rltm_pkg::ID_W-1:0] id_mem    [N];
    logic [TW-1:0]             start_mem [N];
    logic [N-1:0]              slot_vld_reg;
    logic [rltm_pkg::ID_W-1:0] rd_id_reg;
    logic [TW-1:0]             rd_start_reg;
    logic [SCW-1:0]            scnt_reg;
    logic                      sp_v_reg;
    logic [SW-1:0]             sp_idx_reg;
    logic                      hit_reg;
    logic                      free_reg;
    logic                      sfin_reg;
    logic [SW-1:0]             hit_idx_reg;
    logic [SW-1:0]             free_idx_reg;
    logic [TW-1:0]             hit_start_reg;
    logic                      s_issue;
    logic                      slot_wr;
    logic [SW-1:0]             slot_waddr;

    // statistics
    logic [CW-1:0]                 done_reg;
    logic [rltm_pkg::MEAN_W-1:0]   mean_reg;
    logic [CW-1:0]                 last_rate_reg;
    logic [rltm_pkg::WIN_W-1:0]    win_reg;
    logic [TW-1:0]                 lat;
    logic [TW-1:0]                 lq;
    logic                          ge;
    logic [TW-1:0]                 diff;

    // divider
    logic                          div_start;
    logic [TW-1:0]                 div_a;
    logic [rltm_pkg::DIVR_W-1:0]   div_b;
    logic [TW-1:0]                 div_q;
    logic                          div_busy;
    logic                          div_done;

    // bucket ring
    logic [CW-1:0]  bkt_mem [W];
    logic [W-1:0]   bkt_vld_reg;
    logic [CW-1:0]  bkt_rd_reg;
    logic [BW-1:0]  bkt_raddr;
    logic [TW-1:0]  last_idx_reg;
    logic [BW-1:0]  last_pos_reg;
    logic [BW-1:0]  pos_reg;
    logic           clr_all_reg;
    logic [BW-1:0]  gap_reg;
    logic [TW-1:0]  gap_full;
    logic [BW:0]    pos_sum;
    logic [BW-1:0]  pos_nx;
    logic [BCW-1:0] sw_cnt_reg;
    logic           wp_v_reg;
    logic [BW-1:0]  wp_idx_reg;
    logic [SUMW-1:0] sum_reg;
    logic [CW-1:0]  pred_reg;
    logic           wfin_reg;
    logic           sw_issue;
    logic [BW:0]    ring_off;
    logic           zero_it;
    logic [CW-1:0]  nv;
    logic [BW-1:0]  pred_pos;
    logic [SUMW-1:0] sum_nx;
    logic [CW-1:0]  pred_nx;
    logic           sw_last;

    logic           out_v_reg;
    rltm_pkg::rsp_t out_reg;
    rltm_pkg::status_t st;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bms_reg <= rltm_pkg::DEFAULT_BUCKET_MS;
        end
        else if (cfg_valid)
        begin
            bms_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= req_data;
        end
    end

    // table search
    assign s_issue    = cmd.search_step && (scnt_reg < SCW'(N));
    assign slot_wr    = cmd.start_commit && (hit_reg || free_reg);
    assign slot_waddr = hit_reg ? hit_idx_reg : free_idx_reg;

    always_ff @(posedge clk)
    begin
        if (slot_wr)
        begin
            id_mem[slot_waddr]    <= in_reg.request_id;
            start_mem[slot_waddr] <= in_reg.now_ms;
        end
        rd_id_reg    <= id_mem[scnt_reg[SW-1:0]];
        rd_start_reg <= start_mem[scnt_reg[SW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scnt_reg      <= '0;
            sp_v_reg      <= 1'b0;
            sp_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            sfin_reg      <= 1'b0;
            hit_idx_reg   <= '0;
            free_idx_reg  <= '0;
            hit_start_reg <= '0;
        end
        else if (cmd.load)
        begin
            scnt_reg <= '0;
            sp_v_reg <= 1'b0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            sfin_reg <= 1'b0;
        end
        else
        begin
            sp_v_reg   <= s_issue;
            sp_idx_reg <= scnt_reg[SW-1:0];
            if (s_issue)
            begin
                scnt_reg <= scnt_reg + 1'b1;
            end
            if (sp_v_reg)
            begin
                if (slot_vld_reg[sp_idx_reg] && (rd_id_reg == in_reg.request_id) && !hit_reg)
                begin
                    hit_reg       <= 1'b1;
                    hit_idx_reg   <= sp_idx_reg;
                    hit_start_reg <= rd_start_reg;
                end
                if (!slot_vld_reg[sp_idx_reg] && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= sp_idx_reg;
                end
            end
            sfin_reg <= sp_v_reg && (sp_idx_reg == SW'(N - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
        end
        else if (cmd.load && (req_data.op == rltm_pkg::OP_CLEAR))
        begin
            slot_vld_reg <= '0;
        end
        else if (slot_wr)
        begin
            slot_vld_reg[slot_waddr] <= 1'b1;
        end
        else if (cmd.mean_commit)
        begin
            slot_vld_reg[hit_idx_reg] <= 1'b0;
        end
    end

    // running mean
    assign lat  = (in_reg.now_ms >= hit_start_reg) ? (in_reg.now_ms - hit_start_reg) : '0;
    assign lq   = (lat[TW-1:CW] != '0) ? '1 : {lat[CW-1:0], {rltm_pkg::FRAC_W{1'b0}}};
    assign ge   = lq >= mean_reg;
    assign diff = ge ? (lq - mean_reg) : (mean_reg - lq);

    assign div_start = cmd.div_start;

    always_comb
    begin
        case (cmd.div_sel)
            rltm_pkg::DIV_MEAN:
            begin
                div_a = diff;
                div_b = {1'b0, done_reg} + 1'b1;
            end
            default:
            begin
                div_a = in_reg.now_ms;
                div_b = (bms_reg == '0) ? rltm_pkg::DIVR_W'(1)
                                        : rltm_pkg::DIVR_W'(bms_reg);
            end
        endcase
    end

    rltm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_q),
        .busy      (div_busy),
        .done      (div_done)
    );

    // bucket sweep
    assign gap_full  = div_q - last_idx_reg;
    assign pos_sum   = {1'b0, last_pos_reg} + {1'b0, gap_reg};
    assign pos_nx    = clr_all_reg ? '0
                     : (pos_sum >= (BW+1)'(W)) ? BW'(pos_sum - (BW+1)'(W))
                                               : pos_sum[BW-1:0];
    assign sw_issue  = cmd.sweep_step && (sw_cnt_reg < BCW'(W));
    assign bkt_raddr = sw_issue ? sw_cnt_reg[BW-1:0] : pos_reg;
    assign ring_off  = (wp_idx_reg >= last_pos_reg)
                     ? ({1'b0, wp_idx_reg} - {1'b0, last_pos_reg})
                     : ({1'b0, wp_idx_reg} + (BW+1)'(W) - {1'b0, last_pos_reg});
    assign zero_it   = clr_all_reg || ((ring_off != '0) && (ring_off <= {1'b0, gap_reg}));
    assign nv        = zero_it ? '0 : bkt_rd_reg;
    assign pred_pos  = (pos_reg == '0) ? BW'(W - 1) : (pos_reg - 1'b1);
    assign sum_nx    = sum_reg + ((wp_idx_reg != pos_reg) ? SUMW'(nv) : '0);
    assign pred_nx   = (wp_idx_reg == pred_pos) ? nv : pred_reg;
    assign sw_last   = wp_v_reg && (wp_idx_reg == BW'(W - 1));

    always_ff @(posedge clk)
    begin
        if (wp_v_reg)
        begin
            bkt_mem[wp_idx_reg] <= nv;
        end
        else if (cmd.bump)
        begin
            bkt_mem[pos_reg] <= (bkt_rd_reg == '1) ? bkt_rd_reg : (bkt_rd_reg + 1'b1);
        end
        bkt_rd_reg <= bkt_vld_reg[bkt_raddr] ? bkt_mem[bkt_raddr] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkt_vld_reg   <= '0;
            last_idx_reg  <= '0;
            last_pos_reg  <= '0;
            pos_reg       <= '0;
            clr_all_reg   <= 1'b0;
            gap_reg       <= '0;
            sw_cnt_reg    <= '0;
            wp_v_reg      <= 1'b0;
            wp_idx_reg    <= '0;
            sum_reg       <= '0;
            pred_reg      <= '0;
            wfin_reg      <= 1'b0;
            done_reg      <= '0;
            mean_reg      <= '0;
            last_rate_reg <= '0;
            win_reg       <= '0;
        end
        else
        begin
            if (cmd.load && (req_data.op == rltm_pkg::OP_CLEAR))
            begin
                done_reg      <= '0;
                mean_reg      <= '0;
                last_rate_reg <= '0;
                win_reg       <= '0;
            end
            if (cmd.mean_commit)
            begin
                mean_reg <= ge ? (mean_reg + div_q) : (mean_reg - div_q);
                if (done_reg != '1)
                begin
                    done_reg <= done_reg + 1'b1;
                end
            end
            if (cmd.cur_commit)
            begin
                last_idx_reg <= div_q;
                clr_all_reg  <= (div_q < last_idx_reg) || (gap_full >= TW'(W));
                gap_reg      <= gap_full[BW-1:0];
            end
            if (cmd.pos_commit)
            begin
                pos_reg    <= pos_nx;
                sw_cnt_reg <= '0;
                wp_v_reg   <= 1'b0;
                sum_reg    <= '0;
                pred_reg   <= '0;
                wfin_reg   <= 1'b0;
            end
            else
            begin
                wp_v_reg   <= sw_issue;
                wp_idx_reg <= sw_cnt_reg[BW-1:0];
                if (sw_issue)
                begin
                    sw_cnt_reg <= sw_cnt_reg + 1'b1;
                end
                if (wp_v_reg)
                begin
                    sum_reg  <= sum_nx;
                    pred_reg <= pred_nx;
                    bkt_vld_reg[wp_idx_reg] <= 1'b1;
                end
                if (sw_last)
                begin
                    last_rate_reg <= pred_nx;
                    win_reg       <= (sum_nx > SUMW'({rltm_pkg::WIN_W{1'b1}}))
                                   ? '1 : sum_nx[rltm_pkg::WIN_W-1:0];
                    last_pos_reg  <= pos_reg;
                    wfin_reg      <= 1'b1;
                end
            end
            if (cmd.bump)
            begin
                bkt_vld_reg[pos_reg] <= 1'b1;
            end
        end
    end

    // result register
    always_comb
    begin
        case (in_reg.op)
            rltm_pkg::OP_START:  st = (!hit_reg && !free_reg) ? rltm_pkg::ST_FULL
                                                              : rltm_pkg::ST_OK;
            rltm_pkg::OP_FINISH: st = hit_reg ? rltm_pkg::ST_OK : rltm_pkg::ST_NOT_FOUND;
            default:             st = rltm_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_v_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.status                 <= st;
            out_reg.completed_count        <= done_reg;
            out_reg.mean_latency           <= mean_reg;
            out_reg.throughput_last_bucket <= last_rate_reg;
            out_reg.throughput_window      <= win_reg;
        end
    end

    assign rsp_valid = out_v_reg;
    assign rsp_data  = out_reg;

    assign sts.op         = in_reg.op;
    assign sts.search_fin = sfin_reg;
    assign sts.hit        = hit_reg;
    assign sts.div_busy   = div_busy;
    assign sts.div_done   = div_done;
    assign sts.sweep_fin  = wfin_reg;
    assign sts.out_free   = !out_v_reg || rsp_ready;

`ifndef SYNTH
    a_slot_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_wr && !hit_reg) |-> !slot_vld_reg[free_idx_reg])
        else $error("start overwrote an occupied entry");
    a_freed_was_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mean_commit |-> (hit_reg && slot_vld_reg[hit_idx_reg]))
        else $error("finish freed an entry that was not in flight");
    a_sweep_covers: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(wfin_reg) |-> (sw_cnt_reg == BCW'(W)))
        else $error("sweep ended before visiting every bucket");
`endif
endmodule

### hw/rtl/request_latency_throughput_monitor.sv
// ----------------------------------------------------------------------------
// request_latency_throughput_monitor
// Tracks in-flight requests, mean completion latency and bucketed throughput.
// Start and finish search the N in-flight entries one per cycle; query and
//   finish sweep the W buckets one per cycle, and their divisions run on one
//   shared 48-step divider.
// Throughput: one transaction at a time; the next is taken while a result waits.
// Reset: tables empty, ring zero, statistics zero, bucket length 60000 ms.
// ----------------------------------------------------------------------------
module request_latency_throughput_monitor #(
    parameter int IN_FLIGHT_ENTRIES = 16,
    parameter int WINDOW_BUCKETS    = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    rltm_stream_if.sink   req,
    rltm_stream_if.source rsp,
    rltm_stream_if.sink   cfg
);
    rltm_pkg::cmd_t cmd;
    rltm_pkg::sts_t sts;
    rltm_pkg::req_t req_data;
    rltm_pkg::rsp_t rsp_data;

    assign req_data = req.data;
    assign rsp.data = rsp_data;

    rltm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req_data.op),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rltm_dp #(
        .IN_FLIGHT_ENTRIES (IN_FLIGHT_ENTRIES),
        .WINDOW_BUCKETS    (WINDOW_BUCKETS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_data  (req_data),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .cfg_ready (cfg.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp_data)
    );
endmodule
